>>> sv/disk_head_scheduler_assert.svh
// ----------------------------------------------------------------------------
// disk_head_scheduler assertion macros
// shared wrappers for concurrent checks in the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef DISK_HEAD_SCHEDULER_ASSERT_SVH
`define DISK_HEAD_SCHEDULER_ASSERT_SVH

// check that is switched off while reset is high
`define DHS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also covers the reset cycles
`define DHS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/dhs_pkg.sv
// ----------------------------------------------------------------------------
// dhs_pkg
// shared types and constants of the disk head scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dhs_pkg;

   localparam int MAX_REQUESTS_DEF  = 32;
   localparam int CYLINDER_BITS_DEF = 16;

   localparam int POS_W      = 16;
   localparam int KIND_W     = 2;
   localparam int TOT_W      = 22;
   localparam int POLICY_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int RSP_DATA_W = ((POS_W + TOT_W + 1 + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - POS_W - TOT_W - 1;

   localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

   localparam logic [POLICY_W-1:0] POL_SCAN  = 2'd0;
   localparam logic [POLICY_W-1:0] POL_LOOK  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_CSCAN = 2'd2;
   localparam logic [POLICY_W-1:0] POL_CLOOK = 2'd3;

   localparam logic [KIND_W-1:0] KIND_SERVE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_JUMP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_UP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_SIZE = 2'd3;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_FIND,
      ST_HI_UP,
      ST_LO_DOWN,
      ST_LO_UP,
      ST_END_STOP,
      ST_ZERO_STOP,
      ST_JUMP,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> sv/disk_head_scheduler.sv
// ----------------------------------------------------------------------------
// disk_head_scheduler
// SCAN / LOOK / C-SCAN / C-LOOK service order from a sorted row of requests
// ----------------------------------------------------------------------------
// one request item taken per cycle while collecting; each that fits is sorted
// into the cell row on entry; after the last item the split point is found, then
// the sweep phases, stop and jump run in turn and the last result is marked
// an item is released when its successor is made, the last on flush
// synchronous reset: idle and ready, row empty, registers at their reset values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "disk_head_scheduler_assert.svh"

module disk_head_scheduler import dhs_pkg::*; #(
   parameter int MAX_REQUESTS  = MAX_REQUESTS_DEF,
   parameter int CYLINDER_BITS = CYLINDER_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // request_cylinder
   input  wire logic [((CYLINDER_BITS+7)/8)*8-1:0]     req_tdata,
   input  wire logic                                   req_tlast,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // position, total_movement, overflowed
   output logic      [RSP_DATA_W-1:0]                  rsp_tdata,
   // step_kind
   output logic      [KIND_W-1:0]                      rsp_tuser,
   output logic                                        rsp_tlast,
   input  wire logic                                   csr_wen,
   input  wire logic [CSR_IDX_W-1:0]                   csr_index,
   input  wire logic [CYLINDER_BITS:0]                 csr_wdata
);

   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int SUM_W = ((CYLINDER_BITS > TOT_W) ? CYLINDER_BITS : TOT_W) + 1;
   localparam logic [CYLINDER_BITS:0] DISK_FULL = {1'b1, {CYLINDER_BITS{1'b0}}};
   localparam logic [CNT_W-1:0]       CNT_MAX   = CNT_W'(MAX_REQUESTS);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         count_ff;
   logic                     drop_ff;
   logic [CNT_W-1:0]         s_ff;
   logic [CYLINDER_BITS-1:0] end_ff;
   logic [CYLINDER_BITS-1:0] head_ff;
   logic [TOT_W-1:0]         total_ff;

   logic [POLICY_W-1:0]      policy_ff;
   logic                     sweep_up_ff;
   logic [CYLINDER_BITS-1:0] start_ff;
   logic [CYLINDER_BITS:0]   disk_size_ff;

   logic                     pend_valid_ff;
   logic [POS_W-1:0]         pend_pos_ff;
   logic [KIND_W-1:0]        pend_kind_ff;
   logic [TOT_W-1:0]         pend_total_ff;

   logic                     rsp_valid_ff;
   logic [POS_W-1:0]         rsp_pos_ff;
   logic [KIND_W-1:0]        rsp_kind_ff;
   logic [TOT_W-1:0]         rsp_total_ff;
   logic                     rsp_last_ff;
   logic                     rsp_ovf_ff;

   logic                     accept;
   logic                     insert;
   logic                     out_free;
   logic                     gen_room;
   logic                     gen_emit;
   logic [CYLINDER_BITS-1:0] gen_pos;
   logic [KIND_W-1:0]        gen_kind;
   logic                     gen_counted;
   logic                     flush;
   logic                     load_out;
   logic [IDX_W-1:0]         rd_idx;
   logic [CYLINDER_BITS-1:0] rd_data;
   logic [CNT_W-1:0]         chain_s;
   logic [CNT_W-1:0]         s_cur;
   logic [CNT_W-1:0]         idx_m1;
   logic [CYLINDER_BITS:0]   size_m1;
   logic [CYLINDER_BITS-1:0] end_calc;
   logic [CYLINDER_BITS-1:0] move_len;
   logic [SUM_W-1:0]         sum;
   logic [TOT_W-1:0]         total_next;
   logic [CYLINDER_BITS+POS_W-1:0] pos_wide;

   function automatic state_type next_phase(state_type st, logic [POLICY_W-1:0] pol,
                                            logic up);
      state_type nx;
      nx = ST_DONE;
      case (st)
         ST_HI_UP: begin
            if (pol == POL_CSCAN) begin
               nx = ST_END_STOP;
            end else if (pol == POL_CLOOK) begin
               nx = ST_JUMP;
            end else if (up) begin
               nx = (pol == POL_SCAN) ? ST_END_STOP : ST_LO_DOWN;
            end
         end
         ST_END_STOP: begin
            nx = (pol == POL_CSCAN) ? ST_JUMP : ST_LO_DOWN;
         end
         ST_LO_DOWN: begin
            if (!up) begin
               nx = (pol == POL_SCAN) ? ST_ZERO_STOP : ST_HI_UP;
            end
         end
         ST_ZERO_STOP: nx = ST_HI_UP;
         ST_JUMP:      nx = ST_LO_UP;
         default:      nx = ST_DONE;
      endcase
      return nx;
   endfunction

   dhs_chain #(
      .MAX_REQUESTS  (MAX_REQUESTS),
      .CYLINDER_BITS (CYLINDER_BITS)
   ) u_chain (
      .clock       (clock),
      .insert      (insert),
      .req_value   (req_tdata[CYLINDER_BITS-1:0]),
      .start       (start_ff),
      .count       (count_ff),
      .rd_idx      (rd_idx),
      .rd_data     (rd_data),
      .below_count (chain_s)
   );

   assign req_tready = (state_ff == ST_COLLECT);
   assign accept     = req_tvalid && req_tready;
   assign insert     = accept && (count_ff < CNT_MAX);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign gen_room   = !pend_valid_ff || out_free;
   assign s_cur      = (state_ff == ST_FIND) ? chain_s : s_ff;
   assign idx_m1     = idx_ff - 1'b1;

   assign size_m1  = disk_size_ff - 1'b1;
   assign end_calc = (disk_size_ff == '0 || disk_size_ff > DISK_FULL) ?
                     {CYLINDER_BITS{1'b1}} : size_m1[CYLINDER_BITS-1:0];

   // head movement with saturating running total
   assign move_len   = (gen_pos >= head_ff) ? gen_pos - head_ff : head_ff - gen_pos;
   assign sum        = SUM_W'(total_ff) + SUM_W'(move_len);
   assign total_next = !gen_counted ? total_ff :
                       (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOT_W-1:0];
   assign pos_wide   = {{POS_W{1'b0}}, gen_pos};
   assign load_out   = (gen_emit && pend_valid_ff) || flush;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      gen_emit    = 1'b0;
      gen_pos     = rd_data;
      gen_kind    = KIND_SERVE;
      gen_counted = 1'b1;
      rd_idx      = idx_ff[IDX_W-1:0];
      flush       = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            if (accept && req_tlast) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            state_in = (policy_ff != POL_CSCAN && policy_ff != POL_CLOOK && !sweep_up_ff) ?
                       ST_LO_DOWN : ST_HI_UP;
         end
         ST_HI_UP: begin
            if (idx_ff == count_ff) begin
               state_in = next_phase(state_ff, policy_ff, sweep_up_ff);
            end else if (gen_room) begin
               gen_emit = 1'b1;
               idx_in   = idx_ff + 1'b1;
            end
         end
         ST_LO_DOWN: begin
            rd_idx = idx_m1[IDX_W-1:0];
            if (idx_ff == '0) begin
               state_in = next_phase(state_ff, policy_ff, sweep_up_ff);
            end else if (gen_room) begin
               gen_emit = 1'b1;
               idx_in   = idx_m1;
            end
         end
         ST_LO_UP: begin
            if (idx_ff >= s_ff) begin
               state_in = ST_DONE;
            end else if (gen_room) begin
               gen_emit = 1'b1;
               idx_in   = idx_ff + 1'b1;
            end
         end
         ST_END_STOP: begin
            gen_pos  = end_ff;
            gen_kind = KIND_STOP;
            if (head_ff == end_ff) begin
               state_in = next_phase(state_ff, policy_ff, sweep_up_ff);
            end else if (gen_room) begin
               gen_emit = 1'b1;
               state_in = next_phase(state_ff, policy_ff, sweep_up_ff);
            end
         end
         ST_ZERO_STOP: begin
            gen_pos  = '0;
            gen_kind = KIND_STOP;
            if (head_ff == '0) begin
               state_in = ST_HI_UP;
            end else if (gen_room) begin
               gen_emit = 1'b1;
               state_in = ST_HI_UP;
            end
         end
         ST_JUMP: begin
            rd_idx      = '0;
            gen_kind    = KIND_JUMP;
            gen_counted = 1'b0;
            if (policy_ff == POL_CSCAN) begin
               gen_pos = '0;
            end
            if (policy_ff == POL_CLOOK && s_ff == '0) begin
               state_in = ST_LO_UP;
            end else if (gen_room) begin
               gen_emit = 1'b1;
               state_in = ST_LO_UP;
            end
         end
         ST_DONE: begin
            if (!pend_valid_ff) begin
               state_in = ST_COLLECT;
            end else if (out_free) begin
               flush    = 1'b1;
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase

      if (state_in != state_ff) begin
         case (state_in)
            ST_HI_UP:   idx_in = s_cur;
            ST_LO_DOWN: idx_in = s_cur;
            ST_LO_UP:   idx_in = (policy_ff == POL_CLOOK) ? CNT_W'(1) : '0;
            default:    idx_in = idx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_COLLECT;
         idx_ff        <= '0;
         count_ff      <= '0;
         drop_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         policy_ff     <= POL_SCAN;
         sweep_up_ff   <= 1'b1;
         start_ff      <= '0;
         disk_size_ff  <= DISK_FULL;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;

         if (csr_wen) begin
            case (csr_index)
               CSR_POLICY:    policy_ff    <= csr_wdata[POLICY_W-1:0];
               CSR_SWEEP_UP:  sweep_up_ff  <= csr_wdata[0];
               CSR_START_POS: start_ff     <= csr_wdata[CYLINDER_BITS-1:0];
               CSR_DISK_SIZE: disk_size_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (insert) begin
            count_ff <= count_ff + 1'b1;
         end else if (accept) begin
            drop_ff <= 1'b1;
         end

         if (state_ff == ST_FIND) begin
            s_ff     <= chain_s;
            end_ff   <= end_calc;
            head_ff  <= start_ff;
            total_ff <= '0;
         end

         if (gen_emit) begin
            head_ff       <= gen_pos;
            total_ff      <= total_next;
            pend_valid_ff <= 1'b1;
            pend_pos_ff   <= pos_wide[POS_W-1:0];
            pend_kind_ff  <= gen_kind;
            pend_total_ff <= total_next;
         end

         if (load_out) begin
            rsp_valid_ff <= 1'b1;
            rsp_pos_ff   <= pend_pos_ff;
            rsp_kind_ff  <= pend_kind_ff;
            rsp_total_ff <= pend_total_ff;
            rsp_last_ff  <= flush;
            rsp_ovf_ff   <= drop_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (flush) begin
            pend_valid_ff <= 1'b0;
            count_ff      <= '0;
            drop_ff       <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ovf_ff, rsp_total_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `DHS_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> (state_ff == ST_COLLECT && !rsp_valid_ff), "not idle after reset")
   `DHS_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_MAX,
      "request count beyond capacity")
   `DHS_ASSERT(a_pend_not_collect, clock, reset, pend_valid_ff |-> state_ff != ST_COLLECT,
      "held result while collecting")
   `DHS_ASSERT(a_walk_bound, clock, reset,
      (state_ff != ST_COLLECT && state_ff != ST_FIND) |->
      (idx_ff <= count_ff && s_ff <= count_ff), "walk index past stored entries")

endmodule

`default_nettype wire

>>> sv/dhs_cell.sv
// ----------------------------------------------------------------------------
// dhs_cell
// one slot of the sorted request row: shifts up when a smaller item is inserted
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhs_cell import dhs_pkg::*; #(
   parameter int CYLINDER_BITS = CYLINDER_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     insert,
   input  wire logic                     valid,
   input  wire logic                     left_valid,
   input  wire logic                     left_gt,
   input  wire logic [CYLINDER_BITS-1:0] left_value,
   input  wire logic [CYLINDER_BITS-1:0] req_value,
   input  wire logic [CYLINDER_BITS-1:0] start,
   output logic      [CYLINDER_BITS-1:0] value,
   output logic                          gt,
   output logic                          lt
);

   logic [CYLINDER_BITS-1:0] value_ff;
   logic [CYLINDER_BITS-1:0] value_in;
   logic                     take;

   assign gt       = valid && (value_ff > req_value);
   assign lt       = valid && (value_ff < start);
   assign take     = insert && (gt || (!valid && left_valid));
   assign value_in = left_gt ? left_value : req_value;
   assign value    = value_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         value_ff <= value_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/dhs_chain.sv
// ----------------------------------------------------------------------------
// dhs_chain
// row of sorting cells with the split point finder and the read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhs_chain import dhs_pkg::*; #(
   parameter int MAX_REQUESTS  = MAX_REQUESTS_DEF,
   parameter int CYLINDER_BITS = CYLINDER_BITS_DEF,
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1),
   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     insert,
   input  wire logic [CYLINDER_BITS-1:0] req_value,
   input  wire logic [CYLINDER_BITS-1:0] start,
   input  wire logic [CNT_W-1:0]         count,
   input  wire logic [IDX_W-1:0]         rd_idx,
   output logic      [CYLINDER_BITS-1:0] rd_data,
   output logic      [CNT_W-1:0]         below_count
);

   logic [CYLINDER_BITS-1:0] cell_value [MAX_REQUESTS];
   logic [MAX_REQUESTS-1:0]  cell_valid;
   logic [MAX_REQUESTS-1:0]  cell_gt;
   logic [MAX_REQUESTS-1:0]  cell_lt;
   logic [MAX_REQUESTS+1:0]  lt_pre;

   for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
      assign cell_valid[i] = CNT_W'(i) < count;

      if (i == 0) begin : g_head
         dhs_cell #(
            .CYLINDER_BITS(CYLINDER_BITS)
         ) u_cell (
            .clock      (clock),
            .insert     (insert),
            .valid      (cell_valid[i]),
            .left_valid (1'b1),
            .left_gt    (1'b0),
            .left_value (req_value),
            .req_value  (req_value),
            .start      (start),
            .value      (cell_value[i]),
            .gt         (cell_gt[i]),
            .lt         (cell_lt[i])
         );
      end else begin : g_body
         dhs_cell #(
            .CYLINDER_BITS(CYLINDER_BITS)
         ) u_cell (
            .clock      (clock),
            .insert     (insert),
            .valid      (cell_valid[i]),
            .left_valid (cell_valid[i-1]),
            .left_gt    (cell_gt[i-1]),
            .left_value (cell_value[i-1]),
            .req_value  (req_value),
            .start      (start),
            .value      (cell_value[i]),
            .gt         (cell_gt[i]),
            .lt         (cell_lt[i])
         );
      end
   end

   assign rd_data = cell_value[rd_idx];

   // entries below the head form a prefix of the sorted row
   assign lt_pre = {1'b0, cell_lt, 1'b1};

   always_comb begin
      below_count = '0;
      for (int i = 0; i <= MAX_REQUESTS; i++) begin
         if (lt_pre[i] && !lt_pre[i+1]) begin
            below_count = below_count | CNT_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: disk_head_scheduler testbench
// cylinder request batches are streamed in and each service order checked
// against a local scheduler model; a short directed table covers every policy,
// both sweeps, end-stop saturation and empty sides, then random batches with
// random settings, store overruns, random idling and one long output stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import dhs_pkg::*;

   localparam int ROW_DEPTH      = 32;
   localparam int IDLE_PCT       = 29;
   localparam int HOLD_CYCLES    = 300;
   localparam int QUIET_CYCLES   = 8;
   localparam int TAIL_CYCLES    = 20;
   localparam int RANDOM_ITEMS   = 100;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [KIND_W-1:0] kind;
      logic [TOT_W-1:0]  total;
      logic              fin;
      logic              ovf;
   } step_t;

   typedef struct packed {
      logic        is_cfg;
      logic [1:0]  pol;
      logic        up;
      logic [15:0] start;
      logic [16:0] size;
      logic [15:0] cyl;
      logic        last;
      logic [1:0]  n_typed;
      step_t       t0;
      step_t       t1;
   } dir_row_t;

   localparam step_t NO_STEP = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [16:0] csr_wdata = '0;
   wire                    req_tready;
   wire                    rsp_tvalid;
   wire [RSP_DATA_W-1:0]   rsp_tdata;
   wire [KIND_W-1:0]       rsp_tuser;
   wire                    rsp_tlast;

   disk_head_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // scheduler model state
   logic [15:0] cyl_row [ROW_DEPTH];
   int          row_fill = 0;
   bit          row_dropped = 1'b0;
   logic [1:0]  cur_policy = POL_SCAN;
   logic        cur_up = 1'b1;
   logic [15:0] cur_start = '0;
   logic [16:0] cur_size = 17'h10000;
   logic [15:0] head_cyl;
   int          travel;
   step_t       sched [$];
   step_t       service_q [$];
   step_t       typed_q [$];

   int items_sent = 0;
   int batches = 0;
   int overflow_batches = 0;
   int results_seen = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   bit hold_req = 1'b0;

   dir_row_t dir_tab [$];

   function automatic dir_row_t cfg_row(logic [1:0] pol, logic up, logic [15:0] start,
                                        logic [16:0] size);
      dir_row_t r;
      r = '0;
      r.is_cfg = 1'b1;
      r.pol = pol;
      r.up = up;
      r.start = start;
      r.size = size;
      return r;
   endfunction

   function automatic dir_row_t req_row(logic [15:0] cyl, logic last);
      dir_row_t r;
      r = '0;
      r.cyl = cyl;
      r.last = last;
      return r;
   endfunction

   function automatic dir_row_t typed_row(logic [15:0] cyl, logic [1:0] n, step_t t0,
                                          step_t t1);
      dir_row_t r;
      r = req_row(cyl, 1'b1);
      r.n_typed = n;
      r.t0 = t0;
      r.t1 = t1;
      return r;
   endfunction

   function automatic void move_head(logic [15:0] pos, logic [1:0] kind, bit counted);
      int move_len;
      if (counted) begin
         move_len = (pos > head_cyl) ? pos - head_cyl : head_cyl - pos;
         travel += move_len;
         if (travel > int'(TOTAL_MAX))
            travel = int'(TOTAL_MAX);
      end
      head_cyl = pos;
      sched.push_back(step_t'{pos, kind, travel[TOT_W-1:0], 1'b0, row_dropped});
   endfunction

   // sorts one request in; the last one of a batch releases its service order
   function automatic void take_request(logic [15:0] cyl, bit last);
      int i;
      int split;
      logic [15:0] end_cyl;
      if (row_fill < ROW_DEPTH) begin
         i = row_fill;
         while (i > 0 && cyl_row[i-1] > cyl) begin
            cyl_row[i] = cyl_row[i-1];
            i--;
         end
         cyl_row[i] = cyl;
         row_fill++;
      end else begin
         row_dropped = 1'b1;
      end
      if (!last)
         return;
      split = 0;
      while (split < row_fill && cyl_row[split] < cur_start)
         split++;
      end_cyl = (cur_size == 0 || cur_size > 17'h10000) ? 16'hFFFF : 16'(cur_size - 17'd1);
      head_cyl = cur_start;
      travel = 0;
      sched.delete();
      case (cur_policy)
         POL_SCAN, POL_LOOK: begin
            if (cur_up) begin
               for (i = split; i < row_fill; i++) move_head(cyl_row[i], KIND_SERVE, 1'b1);
               if (cur_policy == POL_SCAN && head_cyl != end_cyl)
                  move_head(end_cyl, KIND_STOP, 1'b1);
               for (i = split - 1; i >= 0; i--) move_head(cyl_row[i], KIND_SERVE, 1'b1);
            end else begin
               for (i = split - 1; i >= 0; i--) move_head(cyl_row[i], KIND_SERVE, 1'b1);
               if (cur_policy == POL_SCAN && head_cyl != 16'd0)
                  move_head(16'd0, KIND_STOP, 1'b1);
               for (i = split; i < row_fill; i++) move_head(cyl_row[i], KIND_SERVE, 1'b1);
            end
         end
         POL_CSCAN: begin
            for (i = split; i < row_fill; i++) move_head(cyl_row[i], KIND_SERVE, 1'b1);
            if (head_cyl != end_cyl)
               move_head(end_cyl, KIND_STOP, 1'b1);
            move_head(16'd0, KIND_JUMP, 1'b0);
            for (i = 0; i < split; i++) move_head(cyl_row[i], KIND_SERVE, 1'b1);
         end
         default: begin
            for (i = split; i < row_fill; i++) move_head(cyl_row[i], KIND_SERVE, 1'b1);
            if (split > 0)
               move_head(cyl_row[0], KIND_JUMP, 1'b0);
            for (i = 1; i < split; i++) move_head(cyl_row[i], KIND_SERVE, 1'b1);
         end
      endcase
      sched[sched.size()-1].fin = 1'b1;
      if (typed_q.size() > 0) begin
         foreach (typed_q[k]) service_q.push_back(typed_q[k]);
         typed_q.delete();
      end else begin
         foreach (sched[k]) service_q.push_back(sched[k]);
      end
      batches++;
      if (row_dropped)
         overflow_batches++;
      row_fill = 0;
      row_dropped = 1'b0;
   endfunction

   function automatic logic [15:0] pick_cylinder();
      case ($urandom_range(9))
         0, 1, 2, 3: return 16'($urandom_range(65535));
         4: return cur_start;
         5: return cur_start + 16'($urandom_range(8)) - 16'd4;
         6: return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
         7: return 16'(cur_size) - 16'd1 + 16'($urandom_range(2));
         default: begin
            if (cur_size > 1 && cur_size <= 17'h10000)
               return 16'($urandom_range(int'(cur_size) - 1));
            return 16'($urandom_range(65535));
         end
      endcase
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   task automatic send_item(logic [15:0] cyl, bit last);
      while (!(items_sent >= 60 && items_sent < 100) && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= cyl;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      take_request(cyl, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_batch(int n);
      for (int i = 0; i < n; i++)
         send_item(pick_cylinder(), i == n - 1);
   endtask

   // waits until every pending result is out and the block has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (service_q.size() > 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // upper bits of the narrow registers carry junk that must be ignored
   task automatic write_regs(logic [1:0] pol, logic up, logic [15:0] start,
                             logic [16:0] size);
      csr_wen <= 1'b1;
      csr_index <= CSR_POLICY;
      csr_wdata <= {15'($urandom), pol};
      @(negedge clock);
      csr_index <= CSR_SWEEP_UP;
      csr_wdata <= {16'($urandom), up};
      @(negedge clock);
      csr_index <= CSR_START_POS;
      csr_wdata <= {1'($urandom), start};
      @(negedge clock);
      csr_index <= CSR_DISK_SIZE;
      csr_wdata <= size;
      @(negedge clock);
      csr_wen <= 1'b0;
      cur_policy = pol;
      cur_up = up;
      cur_start = start;
      cur_size = size;
   endtask

   always begin
      step_t want;
      step_t got;
      @(negedge clock);
      if (hold_req) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_req = 1'b0;
      end
      rsp_tready <= (results_seen >= 120 && results_seen < 200) ||
                    $urandom_range(99) >= IDLE_PCT;
      @(posedge clock);
      if (rsp_tvalid && rsp_tready) begin
         got = step_t'{rsp_tdata[POS_W-1:0], rsp_tuser, rsp_tdata[POS_W +: TOT_W],
                       rsp_tlast, rsp_tdata[POS_W+TOT_W]};
         results_seen++;
         if (service_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
         end else begin
            want = service_q.pop_front();
            check_field("position", want.pos, got.pos);
            check_field("step_kind", want.kind, got.kind);
            check_field("total_movement", want.total, got.total);
            check_field("final_step", want.fin, got.fin);
            check_field("overflowed", want.ovf, got.ovf);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int first_random;
      int n;
      dir_tab = '{
         // reset settings: scan up from 0 over the full disk
         typed_row(16'd0, 2'd2, step_t'{16'd0, KIND_SERVE, 22'd0, 1'b0, 1'b0},
                   step_t'{16'hFFFF, KIND_STOP, 22'd65535, 1'b1, 1'b0}),
         cfg_row(POL_LOOK, 1'b1, 16'd0, 17'h10000),
         typed_row(16'hFFFF, 2'd1, step_t'{16'hFFFF, KIND_SERVE, 22'd65535, 1'b1, 1'b0},
                   NO_STEP),
         // request at the head and one past the disk end
         cfg_row(POL_SCAN, 1'b1, 16'd100, 17'd200),
         req_row(16'd50, 1'b0), req_row(16'd100, 1'b0), req_row(16'd300, 1'b0),
         req_row(16'd150, 1'b1),
         cfg_row(POL_SCAN, 1'b0, 16'd100, 17'd200),
         req_row(16'd50, 1'b0), req_row(16'd100, 1'b1),
         // zero and oversize disk sizes saturate the end stop
         cfg_row(POL_LOOK, 1'b0, 16'hFFFF, 17'd0),
         req_row(16'hFFFF, 1'b0), req_row(16'd0, 1'b0), req_row(16'd30000, 1'b1),
         cfg_row(POL_CSCAN, 1'b1, 16'd500, 17'h1FFFF),
         req_row(16'd600, 1'b0), req_row(16'd10, 1'b0), req_row(16'd499, 1'b1),
         // one-cylinder disk, head already on the end stop
         cfg_row(POL_CSCAN, 1'b0, 16'd0, 17'd1),
         req_row(16'd0, 1'b1),
         cfg_row(POL_CLOOK, 1'b1, 16'd1000, 17'd2000),
         req_row(16'd5, 1'b0), req_row(16'd1500, 1'b0), req_row(16'd999, 1'b0),
         req_row(16'd1000, 1'b1),
         // nothing below the head, so no jump
         cfg_row(POL_CLOOK, 1'b0, 16'd1000, 17'd2000),
         req_row(16'd2000, 1'b0), req_row(16'd3000, 1'b1),
         cfg_row(POL_SCAN, 1'b0, 16'd0, 17'h10000),
         req_row(16'hFFFF, 1'b1),
         cfg_row(POL_CSCAN, 1'b1, 16'hFFFF, 17'h10000),
         req_row(16'hFFFF, 1'b0), req_row(16'd0, 1'b1)
      };
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[k]) begin
         if (dir_tab[k].is_cfg) begin
            settle();
            write_regs(dir_tab[k].pol, dir_tab[k].up, dir_tab[k].start, dir_tab[k].size);
         end else begin
            if (dir_tab[k].n_typed > 0)
               typed_q.push_back(dir_tab[k].t0);
            if (dir_tab[k].n_typed > 1)
               typed_q.push_back(dir_tab[k].t1);
            send_item(dir_tab[k].cyl, dir_tab[k].last);
         end
      end

      // output held off while two batches are pushed back to back
      first_random = items_sent;
      settle();
      write_regs(POL_LOOK, 1'b1, 16'd32768, 17'h10000);
      hold_req = 1'b1;
      send_batch(10);
      send_batch(10);

      while (items_sent - first_random < RANDOM_ITEMS || overflow_batches < 2) begin
         if ($urandom_range(99) < 70) begin
            logic [15:0] st;
            logic [16:0] sz;
            case ($urandom_range(3))
               0: st = 16'd0;
               1: st = 16'hFFFF;
               default: st = 16'($urandom_range(65535));
            endcase
            case ($urandom_range(5))
               0: sz = 17'd0;
               1: sz = 17'd1;
               2: sz = 17'h10000;
               3: sz = 17'h1FFFF;
               4: sz = 17'($urandom_range(131071));
               default: sz = 17'($urandom_range(4096, 2));
            endcase
            settle();
            write_regs(2'($urandom_range(3)), 1'($urandom_range(1)), st, sz);
         end
         if (overflow_batches < 2 &&
             (items_sent - first_random > 40 || $urandom_range(5) == 0))
            n = $urandom_range(37, 33);
         else
            n = $urandom_range(12, 1);
         send_batch(n);
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d request items in %0d batches, %0d results checked",
               items_sent, batches, results_seen);
      $display("%0d batches overran the request store; random policy, sweep and size",
               overflow_batches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
